// File: src/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types, constants and functions of the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [1:0] LAST_WORD_IDX = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      count_len;
        logic      latch_len;
        logic      round_en;
        logic [5:0] round_idx;
        logic      update;
        logic      reinit;
        logic [1:0] word_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
    } dp_status_t;

    typedef logic [31:0] word_t;

    function automatic word_t hash_init(input logic [2:0] idx);
        word_t v;
        v = '0;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t v;
        v = '0;
        case (idx)
            6'd0:  v = 32'h428a2f98;
            6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;
            6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;
            6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;
            6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;
            6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;
            6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;
            6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;
            6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;
            6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;
            6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;
            6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;
            6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;
            6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;
            6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;
            6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;
            6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;
            6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;
            6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;
            6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;
            6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;
            6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;
            6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;
            6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;
            6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;
            6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;
            6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;
            6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;
            6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;
            6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;
            6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;
            6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;
            6'd63: v = 32'hc67178f2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

// File: src/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// sha-256 over a byte stream, digest out as four 64-bit words
//
// input channel s_*: one transfer per message byte (s_tuser = 0) or one
// finish transfer (s_tuser = 1) that closes the message.
// output channel m_*: after a finish, four digest words, most significant
// first, word index on m_tuser, m_tlast on the fourth.
// every 64th byte adds a compression (64 rounds of the single round unit,
// one per cycle, plus the hash word update).
// a finish shifts pad and length bytes into the block one per cycle, with a
// pause before the length bytes, and compresses once or twice before the
// first word.
// s_tready is high only while the block waits for input.
// a stalled receiver holds the current digest word; nothing else moves.
// reset loads the initial hash values and clears the byte counts; after
// the last digest word the same state is restored for the next message.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // digest_word
    output logic [1:0]       m_tuser,   // word_index
    output logic             m_tlast    // last_word
);

    sha256_pkg::dp_cmd_t    cmd;
    sha256_pkg::dp_status_t status;

    sha256_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

    sha256_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .data_byte   (s_tdata),
        .digest_word (m_tdata)
    );

    assign m_tuser = cmd.word_idx;

endmodule
`default_nettype wire

// File: src/sha256_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_ctrl
// controller: stream handshakes, padding sequence, round count, digest output
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic                  s_op,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic                       m_tlast,
    output sha256_pkg::dp_cmd_t        cmd,
    input  wire sha256_pkg::dp_status_t status
);

    sha256_pkg::state_t state_reg;
    sha256_pkg::state_t state_next;
    logic       finishing_reg;
    logic       finishing_next;
    logic       final_reg;
    logic       final_next;
    logic [5:0] round_reg;
    logic [5:0] round_next;
    logic [1:0] word_reg;
    logic [1:0] word_next;
    logic       block_full;

    assign block_full = (status.fill == sha256_pkg::LAST_POS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha256_pkg::ST_IDLE;
            finishing_reg <= 1'b0;
            final_reg     <= 1'b0;
            round_reg     <= '0;
            word_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            finishing_reg <= finishing_next;
            final_reg     <= final_next;
            round_reg     <= round_next;
            word_reg      <= word_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (block_full)
                        state_next = sha256_pkg::ST_ROUND;
                    else if (s_op == sha256_pkg::OP_FINISH)
                        state_next = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_PAD:
            begin
                if (status.fill == sha256_pkg::LEN_POS)
                    state_next = sha256_pkg::ST_LEN;
                else if (block_full)
                    state_next = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_LEN:
            begin
                if (block_full)
                    state_next = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_ROUND:
            begin
                if (round_reg == sha256_pkg::LAST_ROUND)
                    state_next = sha256_pkg::ST_UPDATE;
            end
            sha256_pkg::ST_UPDATE:
            begin
                if (final_reg)
                    state_next = sha256_pkg::ST_OUT;
                else if (finishing_reg)
                    state_next = sha256_pkg::ST_PAD;
                else
                    state_next = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_OUT:
            begin
                if (m_tready && word_reg == sha256_pkg::LAST_WORD_IDX)
                    state_next = sha256_pkg::ST_IDLE;
            end
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        m_tlast        = (word_reg == sha256_pkg::LAST_WORD_IDX);
        finishing_next = finishing_reg;
        final_next     = final_reg;
        round_next     = round_reg;
        word_next      = word_reg;
        cmd            = '0;
        cmd.byte_sel   = sha256_pkg::SEL_DATA;
        cmd.round_idx  = round_reg;
        cmd.word_idx   = word_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.shift_en = 1'b1;
                    if (s_op == sha256_pkg::OP_FINISH)
                    begin
                        cmd.byte_sel   = sha256_pkg::SEL_MARK;
                        cmd.latch_len  = 1'b1;
                        finishing_next = 1'b1;
                    end
                    else
                    begin
                        cmd.count_len = 1'b1;
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                if (status.fill != sha256_pkg::LEN_POS)
                begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_sel = sha256_pkg::SEL_ZERO;
                end
            end
            sha256_pkg::ST_LEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = sha256_pkg::SEL_LEN;
                if (block_full)
                    final_next = 1'b1;
            end
            sha256_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
            end
            sha256_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            sha256_pkg::ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    word_next = word_reg + 2'd1;
                    if (word_reg == sha256_pkg::LAST_WORD_IDX)
                    begin
                        cmd.reinit     = 1'b1;
                        finishing_next = 1'b0;
                        final_next     = 1'b0;
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/sha256_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_dp
// datapath: block shift register and message schedule, round unit,
// hash words, byte and length counters, digest word select
// ----------------------------------------------------------------------------
module sha256_dp (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sha256_pkg::dp_cmd_t    cmd,
    output sha256_pkg::dp_status_t      status,
    input  wire logic [7:0]             data_byte,
    output logic [63:0]                 digest_word
);

    logic [511:0] blk_reg;
    logic [511:0] blk_next;
    logic [63:0]  len_shift_reg;
    logic [63:0]  len_shift_next;
    logic [5:0]   fill_reg;
    logic [5:0]   fill_next;
    logic [60:0]  len_reg;
    logic [60:0]  len_next;
    sha256_pkg::word_t hash_reg [8];
    sha256_pkg::word_t hash_next [8];
    sha256_pkg::word_t work_reg [8];
    sha256_pkg::word_t work_next [8];

    logic [7:0]        in_byte;
    sha256_pkg::word_t w_cur;
    sha256_pkg::word_t w_new;
    sha256_pkg::word_t t1;
    sha256_pkg::word_t t2;
    sha256_pkg::word_t ch;
    sha256_pkg::word_t maj;

    assign status.fill = fill_reg;

    always_comb
    begin
        case (cmd.byte_sel)
            sha256_pkg::SEL_DATA: in_byte = data_byte;
            sha256_pkg::SEL_MARK: in_byte = sha256_pkg::PAD_BYTE;
            sha256_pkg::SEL_LEN:  in_byte = len_shift_reg[63:56];
            default:              in_byte = 8'h00;
        endcase
    end

    // round logic
    assign w_cur = blk_reg[511:480];
    assign w_new = w_cur + sha256_pkg::small_sigma0(blk_reg[479:448])
                 + blk_reg[223:192] + sha256_pkg::small_sigma1(blk_reg[63:32]);
    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + sha256_pkg::big_sigma1(work_reg[4]) + ch
               + sha256_pkg::round_k(cmd.round_idx) + w_cur;
    assign t2  = sha256_pkg::big_sigma0(work_reg[0]) + maj;

    always_comb
    begin
        blk_next       = blk_reg;
        len_shift_next = len_shift_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        for (int i = 0; i < 8; i++)
        begin
            hash_next[i] = hash_reg[i];
            work_next[i] = work_reg[i];
        end
        if (cmd.shift_en)
        begin
            blk_next  = {blk_reg[503:0], in_byte};
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.byte_sel == sha256_pkg::SEL_LEN && cmd.shift_en)
            len_shift_next = {len_shift_reg[55:0], 8'h00};
        if (cmd.latch_len)
            len_shift_next = {len_reg, 3'b000};
        if (cmd.count_len)
            len_next = len_reg + 61'd1;
        if (cmd.round_en)
        begin
            blk_next     = {blk_reg[479:0], w_new};
            work_next[0] = t1 + t2;
            work_next[1] = work_reg[0];
            work_next[2] = work_reg[1];
            work_next[3] = work_reg[2];
            work_next[4] = work_reg[3] + t1;
            work_next[5] = work_reg[4];
            work_next[6] = work_reg[5];
            work_next[7] = work_reg[6];
        end
        if (cmd.update)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + work_reg[i];
                work_next[i] = hash_reg[i] + work_reg[i];
            end
        end
        if (cmd.reinit)
        begin
            fill_next = '0;
            len_next  = '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = sha256_pkg::hash_init(3'(i));
                work_next[i] = sha256_pkg::hash_init(3'(i));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha256_pkg::hash_init(3'(i));
                work_reg[i] <= sha256_pkg::hash_init(3'(i));
            end
        end
        else
        begin
            fill_reg <= fill_next;
            len_reg  <= len_next;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_next[i];
                work_reg[i] <= work_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg       <= blk_next;
        len_shift_reg <= len_shift_next;
    end

    always_comb
    begin
        case (cmd.word_idx)
            2'd0:    digest_word = {hash_reg[0], hash_reg[1]};
            2'd1:    digest_word = {hash_reg[2], hash_reg[3]};
            2'd2:    digest_word = {hash_reg[4], hash_reg[5]};
            default: digest_word = {hash_reg[6], hash_reg[7]};
        endcase
    end

endmodule
`default_nettype wire
